// ===== rtl/fwbc_pkg.sv =====
package fwbc_pkg;

  // default geometry
  localparam int WAYS_DEF       = 8;
  localparam int BLOCK_BITS_DEF = 32;

  // line size limit and derived widths
  localparam int MAX_SHIFT = 10;
  localparam int SHIFT_W   = 4;
  localparam int LEN_W     = MAX_SHIFT + 1;

  // flush emits at most this many write-back commands per item
  localparam int MAX_OUT = 8;
  localparam int NOUT_W  = $clog2(MAX_OUT + 1);

  // fixed port widths
  localparam int FIELD_W = 32;
  localparam int SLOT_W  = 3;

  // register index of line_shift, taken from paddr[2]
  localparam logic REG_LINE_SHIFT = 1'b0;

  // request queue between front and back (depth must be a power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_INVAL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_GRANT = 2'd0,
    K_WB    = 2'd1,
    K_DONE  = 2'd2
  } kind_t;

  typedef struct packed {
    op_t  op;
    logic whole_line;
  } req_ctl_t;

endpackage

// ===== rtl/fifo_writeback_block_cache_control.sv =====
// Access (read/write): queue, then result register; one item per cycle when not stalled.
// Flush/invalidate: one line per cycle through the back-end scan;
//   a flush result that meets a stalled output holds the scan until it drains.
// A 2-entry request queue separates input accept from the back end.
// Synchronous active-low reset clears line valid/dirty bits, the FIFO pointer,
//   line_shift and the queue; there is no clearing pass.
module fifo_writeback_block_cache_control import fwbc_pkg::*; #(
  parameter int WAYS       = WAYS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [FIELD_W-1:0] in_block_number,
  input  logic [FIELD_W-1:0] in_block_count,
  input  logic               in_whole_line,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               out_hit,
  output logic               out_evict_writeback,
  output logic [FIELD_W-1:0] out_evict_block,
  output logic               out_fill_needed,
  output logic [FIELD_W-1:0] out_line_block,
  output logic               out_last
);

  logic [SHIFT_W-1:0]    line_shift_r;
  logic [SHIFT_W-1:0]    eff_shift_w;
  logic                  q_valid;
  logic                  q_pop;
  req_ctl_t              q_ctl;
  logic [BLOCK_BITS-1:0] q_block;
  logic [FIELD_W-1:0]    q_count;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_shift_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LINE_SHIFT) begin
      line_shift_r <= pwdata[SHIFT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LINE_SHIFT) ? 32'(line_shift_r) : '0;

  // clamp the line size
  assign eff_shift_w = (line_shift_r > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT)
                                                            : line_shift_r;

  fwbc_front #(
    .BLOCK_BITS (BLOCK_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_block_number (in_block_number),
    .in_block_count  (in_block_count),
    .in_whole_line   (in_whole_line),
    .eff_shift       (eff_shift_w),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_ctl           (q_ctl),
    .q_block         (q_block),
    .q_count         (q_count)
  );

  fwbc_back #(
    .WAYS       (WAYS),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .eff_shift           (eff_shift_w),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_ctl               (q_ctl),
    .q_block             (q_block),
    .q_count             (q_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_slot            (out_slot),
    .out_hit             (out_hit),
    .out_evict_writeback (out_evict_writeback),
    .out_evict_block     (out_evict_block),
    .out_fill_needed     (out_fill_needed),
    .out_line_block      (out_line_block),
    .out_last            (out_last)
  );

endmodule

// ===== rtl/fwbc_front.sv =====
module fwbc_front import fwbc_pkg::*; #(
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [FIELD_W-1:0]    in_block_number,
  input  logic [FIELD_W-1:0]    in_block_count,
  input  logic                  in_whole_line,
  input  logic [SHIFT_W-1:0]    eff_shift,
  output logic                  q_valid,
  input  logic                  q_pop,
  output req_ctl_t              q_ctl,
  output logic [BLOCK_BITS-1:0] q_block,
  output logic [FIELD_W-1:0]    q_count
);

  logic [BLOCK_BITS-1:0] start_w;
  logic [BLOCK_BITS-1:0] mask_w;
  logic [BLOCK_BITS-1:0] block_w;
  req_ctl_t              ctl_w;
  logic                  push_w;

  req_ctl_t              qctl_r [QDEPTH];
  logic [BLOCK_BITS-1:0] qblk_r [QDEPTH];
  logic [FIELD_W-1:0]    qcnt_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_r;
  logic [QPTR_W-1:0]     rd_r;
  logic [QCNT_W-1:0]     cnt_r;

  // classify the item and align accesses down to a line boundary
  assign start_w        = BLOCK_BITS'(in_block_number);
  assign mask_w         = {BLOCK_BITS{1'b1}} << eff_shift;
  assign ctl_w.op       = op_t'(in_mode);
  assign ctl_w.whole_line = in_whole_line;
  assign block_w = (ctl_w.op == OP_READ || ctl_w.op == OP_WRITE) ? (start_w & mask_w)
                                                                 : start_w;

  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push_w   = in_valid && !in_stall;

  // advance queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_w) wr_r <= wr_r + 1'b1;
      if (q_pop)  rd_r <= rd_r + 1'b1;
      case ({push_w, q_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // hold queued payload
  always_ff @(posedge clk) begin
    if (push_w) begin
      qctl_r[wr_r] <= ctl_w;
      qblk_r[wr_r] <= block_w;
      qcnt_r[wr_r] <= in_block_count;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_ctl   = qctl_r[rd_r];
  assign q_block = qblk_r[rd_r];
  assign q_count = qcnt_r[rd_r];

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QCNT_W'(QDEPTH)) |=> !(cnt_r > QCNT_W'(QDEPTH)))
    else $error("queue occupancy overflow");

endmodule

// ===== rtl/fwbc_back.sv =====
module fwbc_back import fwbc_pkg::*; #(
  parameter int WAYS       = WAYS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SHIFT_W-1:0]    eff_shift,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  req_ctl_t              q_ctl,
  input  logic [BLOCK_BITS-1:0] q_block,
  input  logic [FIELD_W-1:0]    q_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [SLOT_W-1:0]     out_slot,
  output logic                  out_hit,
  output logic                  out_evict_writeback,
  output logic [FIELD_W-1:0]    out_evict_block,
  output logic                  out_fill_needed,
  output logic [FIELD_W-1:0]    out_line_block,
  output logic                  out_last
);

  localparam int PW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EW  = ((BLOCK_BITS > FIELD_W) ? BLOCK_BITS : FIELD_W) + 1;
  localparam int BB1 = BLOCK_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t                state_r;
  logic [BLOCK_BITS-1:0] line_tag_r [WAYS];
  logic [WAYS-1:0]       line_valid_r;
  logic [WAYS-1:0]       line_dirty_r;
  logic [PW-1:0]         ptr_r;

  logic [PW-1:0]         idx_r;
  logic                  is_flush_r;
  logic [BLOCK_BITS-1:0] start_r;
  logic [EW-1:0]         end_r;
  logic                  cnz_r;
  logic                  pend_vld_r;
  logic [PW-1:0]         pend_slot_r;
  logic [BLOCK_BITS-1:0] pend_tag_r;
  logic [NOUT_W-1:0]     nout_r;

  logic                  out_valid_r;
  kind_t                 out_kind_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_hit_r;
  logic                  out_evict_writeback_r;
  logic [FIELD_W-1:0]    out_evict_block_r;
  logic                  out_fill_needed_r;
  logic [FIELD_W-1:0]    out_line_block_r;
  logic                  out_last_r;

  logic                  out_free_w;
  logic                  out_load_w;
  logic                  is_access_w;
  logic                  is_write_w;
  logic                  hit_w;
  logic [PW-1:0]         hit_slot_w;
  logic [PW-1:0]         victim_w;
  logic [LEN_W-1:0]      len_w;
  logic [BLOCK_BITS-1:0] tag_s_w;
  logic                  ov_w;
  logic                  qual_w;
  logic                  scan_hold_w;
  logic                  last_idx_w;

  assign out_free_w  = !out_valid_r || !out_stall;
  assign is_access_w = (q_ctl.op == OP_READ) || (q_ctl.op == OP_WRITE);
  assign is_write_w  = (q_ctl.op == OP_WRITE);
  assign q_pop       = (state_r == S_IDLE) && q_valid && out_free_w;

  // parallel tag compare, lowest matching slot wins
  always_comb begin
    hit_w      = 1'b0;
    hit_slot_w = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (line_valid_r[w] && (line_tag_r[w] == q_block)) begin
        hit_w      = 1'b1;
        hit_slot_w = PW'(w);
      end
    end
  end

  // FIFO victim is the slot after the pointer
  assign victim_w = (ptr_r == PW'(WAYS - 1)) ? '0 : ptr_r + 1'b1;

  // range overlap test for the slot under scan
  assign len_w       = LEN_W'(1) << eff_shift;
  assign tag_s_w     = line_tag_r[idx_r];
  assign ov_w        = line_valid_r[idx_r] && cnz_r && (EW'(tag_s_w) < end_r) &&
                       ({1'b0, start_r} < (BB1'(tag_s_w) + BB1'(len_w)));
  assign qual_w      = is_flush_r && ov_w && line_dirty_r[idx_r] &&
                       (nout_r < NOUT_W'(MAX_OUT));
  assign scan_hold_w = qual_w && pend_vld_r && !out_free_w;
  assign last_idx_w  = (idx_r == PW'(WAYS - 1));

  // a new result enters the result register this cycle
  assign out_load_w  = (q_pop && is_access_w) ||
                       (state_r == S_SCAN && !scan_hold_w && qual_w && pend_vld_r) ||
                       (state_r == S_FIN && out_free_w);

  // sequence accesses and range scans, drive the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      line_valid_r <= '0;
      line_dirty_r <= '0;
      ptr_r        <= '0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // load a new result, or drop the old one once taken
      if (out_load_w)      out_valid_r <= 1'b1;
      else if (out_free_w) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (is_access_w) begin
              out_kind_r       <= K_GRANT;
              out_line_block_r <= FIELD_W'(q_block);
              out_last_r       <= 1'b1;
              if (hit_w) begin
                if (is_write_w) line_dirty_r[hit_slot_w] <= 1'b1;
                out_slot_r            <= SLOT_W'(hit_slot_w);
                out_hit_r             <= 1'b1;
                out_evict_writeback_r <= 1'b0;
                out_evict_block_r     <= '0;
                out_fill_needed_r     <= 1'b0;
              end else begin
                ptr_r                  <= victim_w;
                line_tag_r[victim_w]   <= q_block;
                line_valid_r[victim_w] <= 1'b1;
                line_dirty_r[victim_w] <= is_write_w;
                out_slot_r            <= SLOT_W'(victim_w);
                out_hit_r             <= 1'b0;
                out_evict_writeback_r <= line_dirty_r[victim_w];
                out_evict_block_r     <= line_dirty_r[victim_w] ?
                                         FIELD_W'(line_tag_r[victim_w]) : '0;
                out_fill_needed_r     <= !(is_write_w && q_ctl.whole_line);
              end
            end else begin
              is_flush_r <= (q_ctl.op == OP_FLUSH);
              start_r    <= q_block;
              end_r      <= EW'(q_block) + EW'(q_count);
              cnz_r      <= (q_count != '0);
              idx_r      <= '0;
              pend_vld_r <= 1'b0;
              nout_r     <= '0;
              state_r    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!scan_hold_w) begin
            if (qual_w) begin
              line_dirty_r[idx_r] <= 1'b0;
              // release the previous command now that another one follows
              if (pend_vld_r) begin
                out_kind_r            <= K_WB;
                out_slot_r            <= SLOT_W'(pend_slot_r);
                out_hit_r             <= 1'b0;
                out_evict_writeback_r <= 1'b1;
                out_evict_block_r     <= FIELD_W'(pend_tag_r);
                out_fill_needed_r     <= 1'b0;
                out_line_block_r      <= FIELD_W'(pend_tag_r);
                out_last_r            <= 1'b0;
              end
              pend_vld_r  <= 1'b1;
              pend_slot_r <= idx_r;
              pend_tag_r  <= tag_s_w;
              nout_r      <= nout_r + 1'b1;
            end
            if (!is_flush_r && ov_w) begin
              line_valid_r[idx_r] <= 1'b0;
              line_dirty_r[idx_r] <= 1'b0;
            end
            if (last_idx_w) state_r <= S_FIN;
            else            idx_r   <= idx_r + 1'b1;
          end
        end
        S_FIN: begin
          if (out_free_w) begin
            out_hit_r   <= 1'b0;
            out_fill_needed_r <= 1'b0;
            out_last_r  <= 1'b1;
            if (is_flush_r && pend_vld_r) begin
              out_kind_r            <= K_WB;
              out_slot_r            <= SLOT_W'(pend_slot_r);
              out_evict_writeback_r <= 1'b1;
              out_evict_block_r     <= FIELD_W'(pend_tag_r);
              out_line_block_r      <= FIELD_W'(pend_tag_r);
            end else begin
              out_kind_r            <= K_DONE;
              out_slot_r            <= '0;
              out_evict_writeback_r <= 1'b0;
              out_evict_block_r     <= '0;
              out_line_block_r      <= '0;
            end
            pend_vld_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_slot            = out_slot_r;
  assign out_hit             = out_hit_r;
  assign out_evict_writeback = out_evict_writeback_r;
  assign out_evict_block     = out_evict_block_r;
  assign out_fill_needed     = out_fill_needed_r;
  assign out_line_block      = out_line_block_r;
  assign out_last            = out_last_r;

  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (line_dirty_r & ~line_valid_r) == '0)
    else $error("dirty line without valid bit");

  a_wb_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == K_WB) |-> (out_evict_writeback_r && !out_hit_r))
    else $error("write-back command without write-back flag");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (!out_fill_needed_r && !out_evict_writeback_r))
    else $error("hit grant requests fill or eviction");

  a_nout_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (nout_r <= NOUT_W'(MAX_OUT)))
    else $error("too many write-back commands for one flush");

endmodule
